### hdl/dier_pkg.sv
// ----------------------------------------------------------------------------
// dier_pkg
// Shared types and constants of the dual-input edge reporter: register
// indexes, mode and channel codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dier_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LOGIC_MODE    = 2'd0;
  localparam logic [1:0] REG_INVERT_FIRST  = 2'd1;
  localparam logic [1:0] REG_INVERT_SECOND = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE_GAP  = 2'd3;

  // Combination modes
  localparam logic [1:0] MODE_IND = 2'd0;
  localparam logic [1:0] MODE_OR  = 2'd1;
  localparam logic [1:0] MODE_AND = 2'd2;

  // Channel codes of a result
  localparam logic [1:0] CH_COMBINED = 2'd0;
  localparam logic [1:0] CH_FIRST    = 2'd1;
  localparam logic [1:0] CH_SECOND   = 2'd2;

  // Result queue geometry (depth is a power of two)
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;
  localparam int unsigned RQ_CW    = 3;

  typedef struct packed {
    logic [1:0]  mode;
    logic        inv_first;
    logic        inv_second;
    logic [15:0] gap;
  } cfg_t;

  typedef struct packed {
    logic        prev_first;
    logic        prev_second;
    logic [31:0] last_time;
  } st_t;

  typedef struct packed {
    logic [1:0] chan;
    logic       val;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    st_t        st;
  } evl_t;

endpackage

`default_nettype wire

### hdl/dier_eval.sv
// ----------------------------------------------------------------------------
// dier_eval
// Judges one edge event against the stored levels: debounce, then the
// independent, OR or AND rule. Gives up to two results and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module dier_eval
  import dier_pkg::*;
(
  input  wire cfg_t        cfg,
  input  wire st_t         st,
  input  wire logic        level_first,
  input  wire logic        level_second,
  input  wire logic [31:0] event_time,
  output evl_t             evl
);

  logic        a;
  logic        b;
  logic [31:0] elapsed;
  logic        held;
  logic        fire;
  logic        fire_val;

  // Apply inversion and check the debounce window
  assign a       = level_first ^ cfg.inv_first;
  assign b       = level_second ^ cfg.inv_second;
  assign elapsed = event_time - st.last_time;
  assign held    = (cfg.gap != 16'd0) && (elapsed < {16'd0, cfg.gap});

  // Decide the combined report for OR and AND modes
  always_comb begin
    fire     = 1'b0;
    fire_val = 1'b0;
    if (cfg.mode == MODE_OR) begin
      if (!st.prev_first && !st.prev_second) begin
        fire     = a | b;
        fire_val = 1'b1;
      end else begin
        fire     = !a && !b;
        fire_val = 1'b0;
      end
    end else begin
      if (!st.prev_first || !st.prev_second) begin
        fire     = a && b;
        fire_val = 1'b1;
      end else begin
        fire     = !a && !b;
        fire_val = 1'b0;
      end
    end
  end

  // Build results and next state
  always_comb begin
    evl    = '0;
    evl.st = st;
    if (!held) begin
      unique case (cfg.mode)
        MODE_IND: begin
          if (a != st.prev_first) begin
            evl.r0             = '{chan: CH_FIRST, val: a, last: 1'b0};
            evl.n              = 2'd1;
            evl.st.prev_first  = a;
            evl.st.last_time   = event_time;
          end
          if (b != st.prev_second) begin
            if (a != st.prev_first) begin
              evl.r1 = '{chan: CH_SECOND, val: b, last: 1'b0};
            end else begin
              evl.r0 = '{chan: CH_SECOND, val: b, last: 1'b0};
            end
            evl.n              = evl.n + 2'd1;
            evl.st.prev_second = b;
            evl.st.last_time   = event_time;
          end
        end
        MODE_OR: begin
          if (fire) begin
            evl.r0             = '{chan: CH_COMBINED, val: fire_val, last: 1'b0};
            evl.n              = 2'd1;
            evl.st.prev_first  = a;
            evl.st.prev_second = b;
            evl.st.last_time   = event_time;
          end
        end
        MODE_AND: begin
          // AND reports leave the debounce timer alone
          if (fire) begin
            evl.r0             = '{chan: CH_COMBINED, val: fire_val, last: 1'b0};
            evl.n              = 2'd1;
            evl.st.prev_first  = a;
            evl.st.prev_second = b;
          end
        end
        default: begin
          evl.n = 2'd0;
        end
      endcase
    end
    // Mark the final result of this event
    evl.r0.last = (evl.n == 2'd1);
    evl.r1.last = 1'b1;
  end

endmodule

`default_nettype wire

### hdl/dier_rq.sv
// ----------------------------------------------------------------------------
// dier_rq
// Result queue: takes zero, one or two results per cycle and hands them
// out one per cycle under the output valid/stall handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dier_rq
  import dier_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] push_n,
  input  wire res_t       push0,
  input  wire res_t       push1,
  input  wire logic       pop,
  output res_t            head,
  output logic            not_empty,
  output logic            room2
);

  res_t             mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r;
  logic [RQ_AW-1:0] wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r;
  logic [RQ_AW-1:0] rd_ptr_nxt;
  logic [RQ_CW-1:0] count_r;
  logic [RQ_CW-1:0] count_nxt;
  logic             pop_ok;

  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= RQ_CW'(RQ_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];
  assign pop_ok    = pop && not_empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop_ok);
    count_nxt  = count_r + RQ_CW'(push_n) - RQ_CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming results in order
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + RQ_AW'(1)] <= push1;
    end
  end

endmodule

`default_nettype wire

### hdl/dual_input_edge_reporter.sv
// ----------------------------------------------------------------------------
// dual_input_edge_reporter
// Two-channel edge reporter with inversion, debounce and OR/AND combining.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, then evaluated
//   into a four-entry result queue once that has room for two results; the
//   queue head drives the result channel.
// Throughput: one request per cycle while the queue has room for two
//   results; results leave one per cycle while the output is not stalled.
// Reset: synchronous, active low; clears registers, stored levels, timer
//   and the result queue.
`default_nettype none

module dual_input_edge_reporter
  import dier_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input requests
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_level_first,
  input  wire logic        in_level_second,
  input  wire logic [31:0] in_event_time,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_channel_id,
  output logic             out_reported_value,
  output logic             out_last_of_run,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t        cfg_r;
  st_t         st_r;
  logic        s1_valid_r;
  logic        s1_first_r;
  logic        s1_second_r;
  logic [31:0] s1_time_r;
  evl_t        evl;
  logic        room2;
  logic        not_empty;
  logic        take;
  res_t        head;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOGIC_MODE:    cfg_r.mode       <= cfg_data[1:0];
        REG_INVERT_FIRST:  cfg_r.inv_first  <= cfg_data[0];
        REG_INVERT_SECOND: cfg_r.inv_second <= cfg_data[0];
        REG_DEBOUNCE_GAP:  cfg_r.gap        <= cfg_data;
        default:           cfg_r            <= cfg_r;
      endcase
    end
  end

  // Evaluate the held request once the queue has room for two results
  assign take     = s1_valid_r && room2;
  assign in_stall = s1_valid_r && !room2;

  // Hold the accepted request in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_first_r  <= in_level_first;
      s1_second_r <= in_level_second;
      s1_time_r   <= in_event_time;
    end
  end

  dier_eval u_eval (
    .cfg          (cfg_r),
    .st           (st_r),
    .level_first  (s1_first_r),
    .level_second (s1_second_r),
    .event_time   (s1_time_r),
    .evl          (evl)
  );

  // Update stored levels and report time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= evl.st;
    end
  end

  dier_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (take ? evl.n : 2'd0),
    .push0     (evl.r0),
    .push1     (evl.r1),
    .pop       (!out_stall),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // Drive the result channel from the queue head
  assign out_valid          = not_empty;
  assign out_channel_id     = head.chan;
  assign out_reported_value = head.val;
  assign out_last_of_run    = head.last;

endmodule

`default_nettype wire

### hdl/dier_chk.sv
// ----------------------------------------------------------------------------
// dier_chk
// Port-level checks of the dual-input edge reporter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dier_chk
  import dier_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_channel_id,
  input wire logic       out_reported_value,
  input wire logic       out_last_of_run
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_channel_id) &&
      $stable(out_reported_value) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // A combined report is always the only result of its request
  a_comb_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_id == CH_COMBINED |-> out_last_of_run)
    else $error("combined report not marked last");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dual_input_edge_reporter dier_chk u_dier_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_channel_id     (out_channel_id),
  .out_reported_value (out_reported_value),
  .out_last_of_run    (out_last_of_run)
);

`default_nettype wire

### tb/edge_report_checker.sv
// ----------------------------------------------------------------------------
// edge_report_checker
// Watches the request, result and register-write channels of the dual-input
// edge reporter. Keeps its own copy of the registers, stored levels and
// report timer, predicts the results of every accepted request and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module edge_report_checker
  import dier_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_level_first,
  input  logic        in_level_second,
  input  logic [31:0] in_event_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_channel_id,
  input  logic        out_reported_value,
  input  logic        out_last_of_run,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned pending,
  output int unsigned mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        settings;
  st_t         tracked;
  res_t        expected_reports[$];
  int unsigned errors = 0;

  // Work out the reports one edge event causes and queue them in order
  task automatic predict_reports(input logic raw_first, input logic raw_second,
                                 input logic [31:0] stamp);
    logic lvl_a;
    logic lvl_b;
    logic fire;
    logic val;
    res_t found[2];
    int   n;
    int   k;
    lvl_a = raw_first ^ settings.inv_first;
    lvl_b = raw_second ^ settings.inv_second;
    n     = 0;
    fire  = 1'b0;
    val   = 1'b0;

    // Drop events inside the debounce window; nothing changes
    if (settings.gap != 16'd0 && (stamp - tracked.last_time) < 32'(settings.gap))
      return;

    case (settings.mode)
      MODE_IND: begin
        if (lvl_a != tracked.prev_first) begin
          tracked.prev_first = lvl_a;
          found[n] = '{chan: CH_FIRST, val: lvl_a, last: 1'b0};
          n++;
          tracked.last_time = stamp;
        end
        if (lvl_b != tracked.prev_second) begin
          tracked.prev_second = lvl_b;
          found[n] = '{chan: CH_SECOND, val: lvl_b, last: 1'b0};
          n++;
          tracked.last_time = stamp;
        end
      end
      MODE_OR: begin
        if (!tracked.prev_first && !tracked.prev_second) begin
          if (lvl_a || lvl_b) begin
            fire = 1'b1;
            val  = 1'b1;
          end
        end else if (!lvl_a && !lvl_b) begin
          fire = 1'b1;
        end
        if (fire) begin
          found[n] = '{chan: CH_COMBINED, val: val, last: 1'b0};
          n++;
          tracked.last_time   = stamp;
          tracked.prev_first  = lvl_a;
          tracked.prev_second = lvl_b;
        end
      end
      MODE_AND: begin
        if (!tracked.prev_first || !tracked.prev_second) begin
          if (lvl_a && lvl_b) begin
            fire = 1'b1;
            val  = 1'b1;
          end
        end else if (!lvl_a && !lvl_b) begin
          fire = 1'b1;
        end
        // AND reports leave the debounce timer alone
        if (fire) begin
          found[n] = '{chan: CH_COMBINED, val: val, last: 1'b0};
          n++;
          tracked.prev_first  = lvl_a;
          tracked.prev_second = lvl_b;
        end
      end
      default: ;
    endcase

    if (n > 0)
      found[n-1].last = 1'b1;
    for (k = 0; k < n; k++)
      expected_reports.push_back(found[k]);
  endtask

  // Track register writes, predict on requests, check results
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      settings = '0;
      tracked  = '0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOGIC_MODE:    settings.mode       = cfg_data[1:0];
          REG_INVERT_FIRST:  settings.inv_first  = cfg_data[0];
          REG_INVERT_SECOND: settings.inv_second = cfg_data[0];
          REG_DEBOUNCE_GAP:  settings.gap        = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        predict_reports(in_level_first, in_level_second, in_event_time);

      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: channel_id %0d reported_value %0d last_of_run %0d",
                 out_channel_id, out_reported_value, out_last_of_run);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (out_channel_id !== want.chan) begin
            $error("channel_id: expected %0d, actual %0d", want.chan, out_channel_id);
            errors++;
          end
          if (out_reported_value !== want.val) begin
            $error("reported_value: expected %0d, actual %0d", want.val,
                   out_reported_value);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, out_last_of_run);
            errors++;
          end
        end
      end
    end
    pending        <= expected_reports.size();
    mismatch_count <= errors;
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives edge events and register writes into the dual-input edge reporter
// with random idle cycles on the request side and random stalls on the
// result side. A directed pass covers each mode, inversion, wide register
// writes, the unused mode and debounce around the timer wrap; random passes
// then sweep the mode and gap settings. The checker beside the block does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import dier_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_RUNS   = 12;
  localparam int unsigned RUN_EVENTS    = 34;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_level_first = 1'b0;
  logic        in_level_second = 1'b0;
  logic [31:0] in_event_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_channel_id;
  logic        out_reported_value;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int unsigned pending;
  int unsigned mismatch_count;

  int unsigned idle_pct = 6;
  int unsigned stall_pct = 81;
  int unsigned quiet_cycles = 0;
  logic [15:0] gap_now = '0;
  logic [31:0] tick = '0;
  wire         accepted = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                          (cfg_valid && cfg_ready);

  dual_input_edge_reporter u_dut (.*);

  edge_report_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side at random
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || accepted)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Offer one edge event after random idle cycles; hold until accepted
  task automatic send_event(input logic lvl_first, input logic lvl_second,
                            input logic [31:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_level_first  <= lvl_first;
    in_level_second <= lvl_second;
    in_event_time   <= stamp;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Write one register and wait for the handshake; valid stays high
  task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] mode_word, input logic [15:0] inv_a,
                                input logic [15:0] inv_b, input logic [15:0] gap);
    put_reg(REG_LOGIC_MODE, mode_word);
    put_reg(REG_INVERT_FIRST, inv_a);
    put_reg(REG_INVERT_SECOND, inv_b);
    put_reg(REG_DEBOUNCE_GAP, gap);
    cfg_valid <= 1'b0;
    gap_now = gap;
  endtask

  // Drop valid and wait until every report is back and the pipe is empty
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Advance the tick by a step scaled to the gap; now and then jump anywhere
  task automatic random_event();
    logic [31:0] stamp;
    int unsigned span;
    span = (gap_now == 16'd0) ? 64 : 2 * gap_now;
    if ($urandom_range(15) == 0)
      stamp = $urandom();
    else
      stamp = tick + $urandom_range(span);
    tick = stamp;
    send_event(1'($urandom_range(1)), 1'($urandom_range(1)), stamp);
  endtask

  initial begin
    int unsigned run;
    logic [1:0]  mode_pick;
    logic [15:0] junk;
    logic [15:0] gap_pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Independent mode from reset: nothing, each channel, both at once, time extremes
    send_event(1'b0, 1'b0, 32'h0000_0000);
    send_event(1'b1, 1'b0, 32'h0000_0001);
    send_event(1'b1, 1'b1, 32'h0000_0002);
    send_event(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_event(1'b1, 1'b1, 32'h8000_0000);

    // Inversion, written with wide data whose low bit alone counts
    quiesce();
    apply_settings({14'h0000, MODE_IND}, 16'hFFFF, 16'hFFFE, 16'd0);
    send_event(1'b1, 1'b1, 32'h8000_0001);
    send_event(1'b0, 1'b0, 32'h8000_0002);

    // OR combination: hold while one stays active, fall, rise
    quiesce();
    apply_settings({14'h3FFF, MODE_OR}, 16'd0, 16'd0, 16'd0);
    send_event(1'b1, 1'b0, 32'h8000_0003);
    send_event(1'b0, 1'b0, 32'h8000_0004);
    send_event(1'b0, 1'b1, 32'h8000_0005);
    send_event(1'b1, 1'b1, 32'h8000_0006);

    // AND combination: one active only, both active, partial drop, both idle
    quiesce();
    apply_settings({14'h0000, MODE_AND}, 16'd0, 16'd0, 16'd0);
    send_event(1'b1, 1'b0, 32'h8000_0007);
    send_event(1'b1, 1'b1, 32'h8000_0008);
    send_event(1'b0, 1'b1, 32'h8000_0009);
    send_event(1'b0, 1'b0, 32'h8000_000A);

    // Unused mode reports nothing
    quiesce();
    apply_settings({14'h0000, MODE_UNUSED}, 16'd0, 16'd0, 16'd0);
    send_event(1'b1, 1'b1, 32'h8000_000B);
    send_event(1'b0, 1'b1, 32'h8000_000C);

    // Debounce across the timer wrap, exactly at the gap and just inside it
    quiesce();
    apply_settings({14'h0000, MODE_IND}, 16'd0, 16'd0, 16'd5);
    send_event(1'b1, 1'b0, 32'hFFFF_FFF0);
    send_event(1'b0, 1'b0, 32'hFFFF_FFF2);
    send_event(1'b0, 1'b1, 32'hFFFF_FFF5);
    send_event(1'b1, 1'b1, 32'h0000_0001);
    send_event(1'b0, 1'b0, 32'h0000_0005);

    // AND mode under debounce: no report while both stay active, then the fall
    quiesce();
    apply_settings({14'h0000, MODE_AND}, 16'd0, 16'd0, 16'd3);
    send_event(1'b1, 1'b1, 32'h0000_0010);
    send_event(1'b0, 1'b0, 32'h0000_0011);

    // Random runs: every mode against gap off, one, widest and a small random gap
    for (run = 0; run < RANDOM_RUNS; run++) begin
      if (run == RANDOM_RUNS / 3) begin
        idle_pct  = 81;
        stall_pct = 6;
      end else if (run == 2 * RANDOM_RUNS / 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      quiesce();
      case (run % 3)
        0:       mode_pick = MODE_IND;
        1:       mode_pick = MODE_OR;
        default: mode_pick = MODE_AND;
      endcase
      case (run % 4)
        0:       gap_pick = 16'd0;
        1:       gap_pick = 16'd1;
        2:       gap_pick = 16'hFFFF;
        default: gap_pick = 16'($urandom_range(200, 2));
      endcase
      junk = 16'($urandom());
      apply_settings({junk[15:2], mode_pick}, {junk[15:1], 1'($urandom_range(1))},
                     {junk[14:0], 1'($urandom_range(1))}, gap_pick);
      // Start some runs just short of the wrap
      if (run % 2 == 1)
        tick = 32'hFFFF_FFFF - $urandom_range(3000);
      repeat (RUN_EVENTS) random_event();
    end

    quiesce();
    if (mismatch_count == 0 && pending == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

### filelist.f
hdl/dier_pkg.sv
hdl/dier_eval.sv
hdl/dier_rq.sv
hdl/dual_input_edge_reporter.sv
hdl/dier_chk.sv
tb/edge_report_checker.sv
tb/testbench.sv
